// ----- rtl/crt_pkg.sv -----
// Shared types, codes and sizing constants for the retransmit tracker.
// Used by crt_slot_mem, crt_slot_eval and confirmable_retransmit_tracker_core.
// No dependencies.
`timescale 1ns / 1ps

package crt_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int OPCODE_W  = 2;
  localparam int ID_W      = 16;
  localparam int PEER_W    = 48;
  localparam int DELTA_W   = 16;
  localparam int KIND_W    = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int ELAPSED_W = 25;
  localparam int TIMEOUT_W = 24;
  localparam int RETRY_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0]        ACK_TIMEOUT_RESET = 16'd2000;
  localparam logic [RETRY_W-1:0] MAX_RETX_RESET    = 4'd4;

  // Input opcodes.
  localparam logic [OPCODE_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ACK      = 2'd2;

  // Result event kinds.
  localparam logic [KIND_W-1:0] EV_REGISTERED = 3'd0;
  localparam logic [KIND_W-1:0] EV_POOL_FULL  = 3'd1;
  localparam logic [KIND_W-1:0] EV_RETRANSMIT = 3'd2;
  localparam logic [KIND_W-1:0] EV_GIVE_UP    = 3'd3;
  localparam logic [KIND_W-1:0] EV_ACK_MATCH  = 3'd4;
  localparam logic [KIND_W-1:0] EV_ACK_MISS   = 3'd5;
  localparam logic [KIND_W-1:0] EV_TICK_DONE  = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETX    = 1'd1;

  typedef struct packed {
    logic [ID_W-1:0]      msg_id;
    logic [PEER_W-1:0]    peer;
    logic [ELAPSED_W-1:0] elapsed;
    logic [TIMEOUT_W-1:0] timeout;
    logic [RETRY_W-1:0]   retries;
  } slot_entry_t;

  typedef struct packed {
    logic              emit;
    logic              free_slot;
    logic              wr_en;
    logic [KIND_W-1:0] kind;
  } eval_res_t;

endpackage

// ----- rtl/confirmable_retransmit_tracker_core.sv -----
// Top level of the confirmable message retransmit tracker.
// Depends on crt_pkg, crt_slot_mem and crt_slot_eval.
`timescale 1ns / 1ps

// Usage: an item enters on the in_ channel (valid/ready) and carries an
// opcode: register a message, advance time by in_delta, or acknowledge.
// Results leave on the out_ channel (valid/ready), one per cycle at most,
// and the final result of each item has out_last set. Opcode 3 is dropped.
// Configuration writes (ack timeout, retry limit) arrive on the cfg_
// channel, which is ready whenever reset is released; write it only while
// the block is idle. The slot table lives in a small synchronous memory
// with registered read data; valid bits are kept in flip-flops.
// One item is worked on at a time. A register item loads its result once
// the output register is free, and the next item can then be taken. A
// tick or ack walks the slots in order: a free slot is skipped in S_SCAN,
// an occupied slot is read in S_SCAN, then evaluated and written back in
// S_EVAL, and S_FIN sends the closing result once the output register is
// free. Reset clears the valid bits and the output valid flag, and
// restores the configuration defaults; memory contents are not touched.
// When the receiver stalls, the walk holds on the slot whose result is
// pending.
module confirmable_retransmit_tracker_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crt_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [crt_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [crt_pkg::ID_W-1:0]       in_msg_id,
  input  logic [crt_pkg::PEER_W-1:0]     in_peer_address,
  input  logic [crt_pkg::DELTA_W-1:0]    in_delta,
  // result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crt_pkg::KIND_W-1:0]     out_event_kind,
  output logic [crt_pkg::SLOT_OUT_W-1:0] out_slot_index,
  output logic [crt_pkg::ID_W-1:0]       out_msg_id,
  output logic [crt_pkg::PEER_W-1:0]     out_peer_address,
  output logic                           out_last
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_REG  = 5'b00010,
    S_SCAN = 5'b00100,
    S_EVAL = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0]                  ack_timeout_r;
  logic [crt_pkg::RETRY_W-1:0]  max_retx_r;

  // Latched request.
  logic [crt_pkg::OPCODE_W-1:0] op_r;
  logic [crt_pkg::ID_W-1:0]     id_r;
  logic [crt_pkg::PEER_W-1:0]   peer_r;
  logic [crt_pkg::DELTA_W-1:0]  delta_r;

  // Walk control.
  logic [crt_pkg::SLOT_W-1:0]   idx_r, idx_nxt;
  logic                         hit_r, hit_nxt;
  logic [crt_pkg::SLOT_W-1:0]   first_r, first_nxt;
  logic [crt_pkg::SLOT_COUNT-1:0] valid_r, valid_nxt;

  // Output register.
  logic                           out_valid_r, out_valid_nxt;
  logic [crt_pkg::KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic [crt_pkg::SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [crt_pkg::ID_W-1:0]       out_id_r, out_id_nxt;
  logic [crt_pkg::PEER_W-1:0]     out_peer_r, out_peer_nxt;
  logic                           out_last_r, out_last_nxt;

  // Memory ports.
  logic                       mem_wr_en;
  logic [crt_pkg::SLOT_W-1:0] mem_wr_addr;
  crt_pkg::slot_entry_t       mem_wr_data;
  logic                       mem_rd_en;
  crt_pkg::slot_entry_t       mem_rd_data;

  crt_pkg::slot_entry_t       eval_entry;
  crt_pkg::eval_res_t         eval_res;

  logic                       out_free;
  logic                       idx_last;
  logic                       free_found;
  logic [crt_pkg::SLOT_W-1:0] free_idx;

  assign cfg_ready = rst_n;
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign idx_last  = (idx_r == crt_pkg::SLOT_W'(crt_pkg::SLOT_COUNT - 1));

  crt_slot_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_r),
    .rd_data (mem_rd_data)
  );

  crt_slot_eval u_eval (
    .op        (op_r),
    .entry     (mem_rd_data),
    .delta     (delta_r),
    .max_retx  (max_retx_r),
    .req_id    (id_r),
    .req_peer  (peer_r),
    .new_entry (eval_entry),
    .res       (eval_res)
  );

  // Lowest free slot for registration.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = crt_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = crt_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    first_nxt     = first_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_id_nxt    = out_id_r;
    out_peer_nxt  = out_peer_r;
    out_last_nxt  = out_last_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = idx_r;
    mem_wr_data   = eval_entry;
    mem_rd_en     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          hit_nxt = 1'b0;
          case (in_opcode)
            crt_pkg::OP_REGISTER: state_nxt = S_REG;
            crt_pkg::OP_TICK:     state_nxt = S_SCAN;
            crt_pkg::OP_ACK:      state_nxt = S_SCAN;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end

      S_REG: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = id_r;
          out_peer_nxt  = peer_r;
          out_last_nxt  = 1'b1;
          if (free_found) begin
            mem_wr_en           = 1'b1;
            mem_wr_addr         = free_idx;
            mem_wr_data.msg_id  = id_r;
            mem_wr_data.peer    = peer_r;
            mem_wr_data.elapsed = '0;
            mem_wr_data.timeout = crt_pkg::TIMEOUT_W'(ack_timeout_r);
            mem_wr_data.retries = '0;
            valid_nxt[free_idx] = 1'b1;
            out_kind_nxt        = crt_pkg::EV_REGISTERED;
            out_slot_nxt        = crt_pkg::SLOT_OUT_W'(free_idx);
          end else begin
            out_kind_nxt = crt_pkg::EV_POOL_FULL;
            out_slot_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        if (valid_r[idx_r]) begin
          mem_rd_en = 1'b1;
          state_nxt = S_EVAL;
        end else if (idx_last) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_EVAL: begin
        // Hold on this slot while a result of it cannot be loaded.
        if (!eval_res.emit || out_free) begin
          mem_wr_en = eval_res.wr_en;
          if (eval_res.free_slot) begin
            valid_nxt[idx_r] = 1'b0;
          end
          if (eval_res.free_slot && (op_r == crt_pkg::OP_ACK) && !hit_r) begin
            hit_nxt   = 1'b1;
            first_nxt = idx_r;
          end
          if (eval_res.emit) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = eval_res.kind;
            out_slot_nxt  = crt_pkg::SLOT_OUT_W'(idx_r);
            out_id_nxt    = mem_rd_data.msg_id;
            out_peer_nxt  = mem_rd_data.peer;
            out_last_nxt  = 1'b0;
          end
          if (idx_last) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (op_r == crt_pkg::OP_TICK) begin
            out_kind_nxt = crt_pkg::EV_TICK_DONE;
            out_slot_nxt = '0;
            out_id_nxt   = '0;
            out_peer_nxt = '0;
          end else begin
            out_id_nxt   = id_r;
            out_peer_nxt = peer_r;
            if (hit_r) begin
              out_kind_nxt = crt_pkg::EV_ACK_MATCH;
              out_slot_nxt = crt_pkg::SLOT_OUT_W'(first_r);
            end else begin
              out_kind_nxt = crt_pkg::EV_ACK_MISS;
              out_slot_nxt = '0;
            end
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
      ack_timeout_r <= crt_pkg::ACK_TIMEOUT_RESET;
      max_retx_r    <= crt_pkg::MAX_RETX_RESET;
      idx_r         <= '0;
      hit_r         <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          crt_pkg::CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_data;
          crt_pkg::CFG_MAX_RETX:    max_retx_r    <= cfg_data[crt_pkg::RETRY_W-1:0];
          default:                  ack_timeout_r <= ack_timeout_r;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    first_r    <= first_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_id_r   <= out_id_nxt;
    out_peer_r <= out_peer_nxt;
    out_last_r <= out_last_nxt;
    if (in_valid && in_ready) begin
      op_r    <= in_opcode;
      id_r    <= in_msg_id;
      peer_r  <= in_peer_address;
      delta_r <= in_delta;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_slot_index   = out_slot_r;
  assign out_msg_id       = out_id_r;
  assign out_peer_address = out_peer_r;
  assign out_last         = out_last_r;

  // A slot is only evaluated when it holds a pending message.
  a_eval_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> valid_r[idx_r])
    else $error("slot evaluated while not valid");

  // The walk stays on a slot whose result cannot yet be loaded.
  a_eval_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && eval_res.emit && !out_free)
      |=> (state_r == S_EVAL) && $stable(idx_r))
    else $error("walk advanced past a stalled result");

  // Tick done always closes an item; per-slot events never do.
  a_tick_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == crt_pkg::EV_TICK_DONE) |-> out_last_r)
    else $error("tick done without last");

  a_slot_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == crt_pkg::EV_RETRANSMIT ||
                     out_kind_r == crt_pkg::EV_GIVE_UP)) |-> !out_last_r)
    else $error("slot event marked last");

  // New items are taken only with no walk or registration in progress.
  a_accept_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_EVAL || state_r == S_FIN) |-> !in_ready)
    else $error("input accepted during a walk");

endmodule

// ----- rtl/crt_slot_mem.sv -----
// Slot table storage: one write port, one read port, registered read data.
// Depends on crt_pkg for the entry type and the slot count.
`timescale 1ns / 1ps

module crt_slot_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [crt_pkg::SLOT_W-1:0] wr_addr,
  input  crt_pkg::slot_entry_t       wr_data,
  input  logic                       rd_en,
  input  logic [crt_pkg::SLOT_W-1:0] rd_addr,
  output crt_pkg::slot_entry_t       rd_data
);

  crt_pkg::slot_entry_t mem_r [crt_pkg::SLOT_COUNT];
  crt_pkg::slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/crt_slot_eval.sv -----
// Per-slot update for tick and ack walks: ages, retransmits, gives up or matches.
// Depends on crt_pkg for the entry and result types.
`timescale 1ns / 1ps

module crt_slot_eval (
  input  logic [crt_pkg::OPCODE_W-1:0] op,
  input  crt_pkg::slot_entry_t         entry,
  input  logic [crt_pkg::DELTA_W-1:0]  delta,
  input  logic [crt_pkg::RETRY_W-1:0]  max_retx,
  input  logic [crt_pkg::ID_W-1:0]     req_id,
  input  logic [crt_pkg::PEER_W-1:0]   req_peer,
  output crt_pkg::slot_entry_t         new_entry,
  output crt_pkg::eval_res_t           res
);

  logic [crt_pkg::ELAPSED_W:0]   sum;
  logic [crt_pkg::ELAPSED_W-1:0] elapsed_sat;
  logic [crt_pkg::TIMEOUT_W:0]   dbl;
  logic [crt_pkg::TIMEOUT_W-1:0] timeout_sat;
  logic                          expired;

  always_comb begin
    sum = {1'b0, entry.elapsed} + (crt_pkg::ELAPSED_W + 1)'(delta);
    elapsed_sat = sum[crt_pkg::ELAPSED_W] ? '1 : sum[crt_pkg::ELAPSED_W-1:0];
    expired = {1'b0, elapsed_sat} >= (crt_pkg::ELAPSED_W + 1)'(entry.timeout);
    dbl = {entry.timeout, 1'b0};
    timeout_sat = dbl[crt_pkg::TIMEOUT_W] ? '1 : dbl[crt_pkg::TIMEOUT_W-1:0];
  end

  always_comb begin
    new_entry = entry;
    res = '0;
    case (op)
      crt_pkg::OP_TICK: begin
        new_entry.elapsed = elapsed_sat;
        res.wr_en = 1'b1;
        if (expired) begin
          res.emit = 1'b1;
          if (entry.retries >= max_retx) begin
            res.free_slot = 1'b1;
            res.wr_en = 1'b0;
            res.kind = crt_pkg::EV_GIVE_UP;
          end else begin
            new_entry.timeout = timeout_sat;
            new_entry.retries = entry.retries + 1'b1;
            new_entry.elapsed = '0;
            res.kind = crt_pkg::EV_RETRANSMIT;
          end
        end
      end
      crt_pkg::OP_ACK: begin
        res.free_slot = (entry.msg_id == req_id) && (entry.peer == req_peer);
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule
